// ===== src/sensor_frame_sync_decoder_top_macros.svh =====
// Assertion macros shared by the frame sync decoder RTL.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef SENSOR_FRAME_SYNC_DECODER_TOP_MACROS_SVH
`define SENSOR_FRAME_SYNC_DECODER_TOP_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define SFSD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define SFSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sfsd_pkg.sv =====
// Shared types and constants for the sensor frame sync decoder.
// No dependencies; imported by every module of the block.
package sfsd_pkg;

   localparam int WIN_LEN   = 8;
   localparam int WIN_IDX_W = 3;
   localparam int FILL_W    = 4;
   localparam int FQ_DEPTH  = 2;
   localparam int FQ_PTR_W  = 1;
   localparam int FQ_CNT_W  = 2;
   localparam int OQ_DEPTH  = 4;
   localparam int OQ_PTR_W  = 2;
   localparam int OQ_CNT_W  = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 23;

   localparam logic [7:0]  SYNC_BYTE_RST     = 8'd1;
   localparam logic [7:0]  VELOCITY_GAIN_RST = 8'd4;
   localparam logic [7:0]  RPM_GAIN_RST      = 8'd50;
   localparam logic [16:0] TEMP_GAIN_RST     = 17'd95515;
   localparam logic signed [22:0] TEMP_OFFSET_RST = -23'sd2572400;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_BYTE     = 3'd0,
      CSR_VELOCITY_GAIN = 3'd1,
      CSR_RPM_GAIN      = 3'd2,
      CSR_TEMP_GAIN     = 3'd3,
      CSR_TEMP_OFFSET   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0]         sync_byte;
      logic [7:0]         velocity_gain;
      logic [7:0]         rpm_gain;
      logic [16:0]        temp_gain;
      logic signed [22:0] temp_offset;
   } cfg_type;

   // Payload bytes of one checked frame (sync and checksum dropped).
   typedef struct packed {
      logic [7:0] vel_hi;
      logic [7:0] vel_lo;
      logic [7:0] rpm;
      logic [7:0] eng_temp;
      logic [7:0] flags;
      logic [7:0] air;
   } frame_type;

   typedef struct packed {
      logic [23:0]        velocity_tenths;
      logic [15:0]        engine_speed;
      logic signed [26:0] engine_temp;
      logic [7:0]         air_temp;
      logic               front_brake;
      logic               rear_brake;
      logic               left_turn;
      logic               right_turn;
      logic               parking_light;
   } result_type;

endpackage

// ===== src/sensor_frame_sync_decoder_top.sv =====
// Path: a frame's last byte writes its payload into the frame queue; the multiply
// stage registers the scaled fields, which then enter the result queue for popping.
// Throughput: one byte per cycle while full is low; full rises only when two checked frames wait
// in the front queue because the result queue (four entries) is not drained.
// Reset: synchronous, active high; clears the window fill count, both queues
// and the multiply stage, and loads the registers with their default values.
// Depends on sfsd_pkg, sfsd_front and sfsd_back.
module sensor_frame_sync_decoder_top import sfsd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // byte input channel
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_rx_byte,
   // decoded result channel
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [23:0]           rsp_velocity_tenths,
   output logic [15:0]           rsp_engine_speed,
   output logic signed [26:0]    rsp_engine_temp,
   output logic [7:0]            rsp_air_temp,
   output logic                  rsp_front_brake,
   output logic                  rsp_rear_brake,
   output logic                  rsp_left_turn,
   output logic                  rsp_right_turn,
   output logic                  rsp_parking_light,
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       frame_valid;
   logic       frame_pop;
   frame_type  frame;
   result_type rsp;

   // Register file: take the low bits that fit each register, drop writes to
   // unused indexes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SYNC_BYTE:     cfg_in.sync_byte     = csr_wdata[7:0];
            CSR_VELOCITY_GAIN: cfg_in.velocity_gain = csr_wdata[7:0];
            CSR_RPM_GAIN:      cfg_in.rpm_gain      = csr_wdata[7:0];
            CSR_TEMP_GAIN:     cfg_in.temp_gain     = csr_wdata[16:0];
            CSR_TEMP_OFFSET:   cfg_in.temp_offset   = signed'(csr_wdata[22:0]);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte     <= SYNC_BYTE_RST;
         cfg_ff.velocity_gain <= VELOCITY_GAIN_RST;
         cfg_ff.rpm_gain      <= RPM_GAIN_RST;
         cfg_ff.temp_gain     <= TEMP_GAIN_RST;
         cfg_ff.temp_offset   <= TEMP_OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: shift each beat into the window, check sync and checksum, and
   // queue the payload bytes of every frame that passes.
   sfsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_pop   (frame_pop)
   );

   // Back: scale the fields in one multiply stage, add the temperature
   // offset, and hold finished results until the consumer pops them.
   sfsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_pop   (frame_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp         (rsp)
   );

   assign rsp_velocity_tenths = rsp.velocity_tenths;
   assign rsp_engine_speed    = rsp.engine_speed;
   assign rsp_engine_temp     = rsp.engine_temp;
   assign rsp_air_temp        = rsp.air_temp;
   assign rsp_front_brake     = rsp.front_brake;
   assign rsp_rear_brake      = rsp.rear_brake;
   assign rsp_left_turn       = rsp.left_turn;
   assign rsp_right_turn      = rsp.right_turn;
   assign rsp_parking_light   = rsp.parking_light;

endmodule

// ===== src/sfsd_front.sv =====
// Front end: sliding byte window, sync and checksum check, frame queue.
// Depends on sfsd_pkg and sensor_frame_sync_decoder_top_macros.svh.
`include "sensor_frame_sync_decoder_top_macros.svh"

module sfsd_front import sfsd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      req_push,
   input  logic [7:0] req_rx_byte,
   output logic      req_full,
   output logic      frame_valid,
   output frame_type frame,
   input  logic      frame_pop
);

   logic [7:0]          win_ff [WIN_LEN];
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [7:0]          cand [WIN_LEN];
   logic [7:0]          sum;
   logic                win_full, check_en, frame_ok, accept, fq_push;

   frame_type           fq_mem_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0] fq_wr_ff, fq_wr_in, fq_rd_ff, fq_rd_in;
   logic [FQ_CNT_W-1:0] fq_cnt_ff, fq_cnt_in;

   // Window as it stands once this beat is shifted in.
   always_comb begin
      win_full = (fill_ff == FILL_W'(WIN_LEN));
      check_en = (fill_ff >= FILL_W'(WIN_LEN - 1));
      for (int i = 0; i < WIN_LEN - 1; i++) begin
         cand[i] = win_full ? win_ff[i+1] : win_ff[i];
      end
      cand[WIN_LEN-1] = req_rx_byte;
      sum = 8'd0;
      for (int i = 1; i < WIN_LEN - 1; i++) begin
         sum = sum + cand[i];
      end
      frame_ok = check_en && (cand[0] == cfg.sync_byte) && (sum == cand[WIN_LEN-1]);
   end

   assign req_full = (fq_cnt_ff == FQ_CNT_W'(FQ_DEPTH));
   assign accept   = req_push && !req_full;
   assign fq_push  = accept && frame_ok;

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (frame_ok) begin
            fill_in = '0;
         end else if (!win_full) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Window payload: append while filling, slide once full.
   always_ff @(posedge clock) begin
      if (accept && !frame_ok) begin
         if (!win_full) begin
            win_ff[fill_ff[WIN_IDX_W-1:0]] <= req_rx_byte;
         end else begin
            for (int i = 0; i < WIN_LEN; i++) begin
               win_ff[i] <= cand[i];
            end
         end
      end
   end

   // Frame queue toward the back end.
   always_comb begin
      fq_wr_in  = fq_wr_ff + FQ_PTR_W'(fq_push);
      fq_rd_in  = fq_rd_ff + FQ_PTR_W'(frame_pop);
      fq_cnt_in = fq_cnt_ff + FQ_CNT_W'(fq_push) - FQ_CNT_W'(frame_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fq_wr_ff  <= '0;
         fq_rd_ff  <= '0;
         fq_cnt_ff <= '0;
      end else begin
         fq_wr_ff  <= fq_wr_in;
         fq_rd_ff  <= fq_rd_in;
         fq_cnt_ff <= fq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fq_push) begin
         fq_mem_ff[fq_wr_ff] <= '{vel_hi:   cand[1], vel_lo: cand[2], rpm: cand[3],
                                  eng_temp: cand[4], flags:  cand[5], air: cand[6]};
      end
   end

   assign frame_valid = (fq_cnt_ff != '0);
   assign frame       = fq_mem_ff[fq_rd_ff];

   `SFSD_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= FILL_W'(WIN_LEN),
      "window fill count beyond window length")
   `SFSD_ASSERT_NEXT(a_frame_empties_window, fq_push, fill_ff == '0,
      "accepted frame did not empty the window")
   `SFSD_ASSERT_NOW(a_pop_needs_frame, frame_pop, frame_valid,
      "frame queue popped while empty")

endmodule

// ===== src/sfsd_back.sv =====
// Back end: gain multiplies, offset add and the result queue.
// Depends on sfsd_pkg and sensor_frame_sync_decoder_top_macros.svh.
`include "sensor_frame_sync_decoder_top_macros.svh"

module sfsd_back import sfsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       frame_valid,
   input  frame_type  frame,
   output logic       frame_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output result_type rsp
);

   logic                s1_valid_ff;
   logic [23:0]         s1_vel_ff;
   logic [15:0]         s1_rpm_ff;
   logic [24:0]         s1_temp_ff;
   logic [7:0]          s1_air_ff;
   logic [7:0]          s1_flags_ff;
   logic                issue, oq_push, oq_pop;
   logic [OQ_CNT_W:0]   in_flight;
   result_type          s2_res;

   result_type          oq_mem_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] oq_wr_ff, oq_wr_in, oq_rd_ff, oq_rd_in;
   logic [OQ_CNT_W-1:0] oq_cnt_ff, oq_cnt_in;

   // Reserve a queue slot for the frame in the multiply stage.
   assign in_flight = {1'b0, oq_cnt_ff} + (OQ_CNT_W+1)'(s1_valid_ff);
   assign issue     = frame_valid && (in_flight < (OQ_CNT_W+1)'(OQ_DEPTH));
   assign frame_pop = issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_vel_ff   <= 24'({frame.vel_hi, frame.vel_lo}) * 24'(cfg.velocity_gain);
         s1_rpm_ff   <= 16'(frame.rpm) * 16'(cfg.rpm_gain);
         s1_temp_ff  <= 25'(frame.eng_temp) * 25'(cfg.temp_gain);
         s1_air_ff   <= frame.air;
         s1_flags_ff <= frame.flags;
      end
   end

   always_comb begin
      s2_res.velocity_tenths = s1_vel_ff;
      s2_res.engine_speed    = s1_rpm_ff;
      s2_res.engine_temp     = signed'({2'b00, s1_temp_ff})
                             + 27'(cfg.temp_offset);
      s2_res.air_temp        = s1_air_ff;
      s2_res.front_brake     = s1_flags_ff[2];
      s2_res.rear_brake      = s1_flags_ff[3];
      s2_res.left_turn       = s1_flags_ff[0];
      s2_res.right_turn      = s1_flags_ff[1];
      s2_res.parking_light   = s1_flags_ff[4];
   end

   assign oq_push = s1_valid_ff;
   assign oq_pop  = rsp_pop && !rsp_empty;

   always_comb begin
      oq_wr_in  = oq_wr_ff + OQ_PTR_W'(oq_push);
      oq_rd_in  = oq_rd_ff + OQ_PTR_W'(oq_pop);
      oq_cnt_in = oq_cnt_ff + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_mem_ff[oq_wr_ff] <= s2_res;
      end
   end

   assign rsp_empty = (oq_cnt_ff == '0);
   assign rsp       = oq_mem_ff[oq_rd_ff];

   `SFSD_ASSERT_NOW(a_no_overflow, oq_push, oq_cnt_ff < OQ_CNT_W'(OQ_DEPTH),
      "result queue written while full")
   `SFSD_ASSERT_NEXT(a_issue_reaches_stage, issue, s1_valid_ff,
      "issued frame missing from multiply stage")
   `SFSD_ASSERT_NOW(a_slot_budget, 1'b1, in_flight <= (OQ_CNT_W+1)'(OQ_DEPTH),
      "results in flight exceed result queue depth")

endmodule
